FILE: rtl/core/alsb_pkg.sv
// shared types, constants and the address window check for the slave bridge
// no dependencies; imported by every module of the block
`default_nettype none

package alsb_pkg;

    // packed stream widths, padded to whole bytes
    localparam int IN_BITS  = 106;
    localparam int IN_W     = 112;
    localparam int OUT_BITS = 107;
    localparam int OUT_W    = 112;

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW_BASE = 2'd0;
    localparam logic [1:0] REG_WINDOW_TOP  = 2'd1;

    // phase codes shared by both machines
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ADDR = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_LAST = 2'd3;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] top;
    } win_t;

    typedef struct packed {
        logic        addr_valid;
        logic [31:0] addr;
        logic        local_ready;
    } rd_in_t;

    typedef struct packed {
        logic        addr_ready;
        logic        data_valid;
        logic [31:0] offset;
        logic        request;
    } rd_out_t;

    typedef struct packed {
        logic        addr_valid;
        logic [31:0] addr;
        logic        data_valid;
        logic [31:0] data;
        logic [3:0]  strobe;
        logic        local_ready;
        logic        resp_ready;
    } wr_in_t;

    typedef struct packed {
        logic        addr_ready;
        logic        data_ready;
        logic        resp_valid;
        logic [31:0] offset;
        logic [31:0] data;
        logic [3:0]  strobe;
        logic        request;
    } wr_out_t;

    function automatic logic in_window(input logic [31:0] a, input win_t w);
        return (a >= w.base) && (a < w.top);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/alsb_rd_fsm.sv
// read-side handshake machine: idle, address, wait for data, response
// depends on alsb_pkg
`default_nettype none

module alsb_rd_fsm (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire alsb_pkg::win_t  win,
    input  wire alsb_pkg::rd_in_t rd_in,
    output alsb_pkg::rd_out_t    rd_out
);
    import alsb_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic        arready_reg, arready_next;
    logic        rvalid_reg, rvalid_next;
    logic        req_reg, req_next;
    logic [31:0] offset_reg, offset_next;

    always_comb begin
        phase_next   = phase_reg;
        arready_next = arready_reg;
        rvalid_next  = rvalid_reg;
        req_next     = req_reg;
        offset_next  = offset_reg;
        case (phase_reg)
            PH_IDLE: begin
                arready_next = 1'b0;
                rvalid_next  = 1'b0;
                phase_next   = PH_ADDR;
            end
            PH_ADDR: begin
                if (rd_in.addr_valid && in_window(rd_in.addr, win)) begin
                    offset_next = rd_in.addr - win.base;
                    req_next    = 1'b1;
                    phase_next  = PH_WAIT;
                end
            end
            PH_WAIT: begin
                arready_next = 1'b1;
                if (!rd_in.local_ready) begin
                    rvalid_next = 1'b1;
                    req_next    = 1'b0;
                    phase_next  = PH_LAST;
                end
            end
            default: begin
                if (rd_in.local_ready) begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            arready_reg <= 1'b0;
            rvalid_reg  <= 1'b0;
            req_reg     <= 1'b0;
            offset_reg  <= '0;
        end else if (en) begin
            phase_reg   <= phase_next;
            arready_reg <= arready_next;
            rvalid_reg  <= rvalid_next;
            req_reg     <= req_next;
            offset_reg  <= offset_next;
        end
    end

    assign rd_out.addr_ready = arready_reg;
    assign rd_out.data_valid = rvalid_reg;
    assign rd_out.offset     = offset_reg;
    assign rd_out.request    = req_reg;

endmodule

`default_nettype wire

FILE: rtl/core/alsb_wr_fsm.sv
// write-side handshake machine: idle, address, local ack, response
// depends on alsb_pkg
`default_nettype none

module alsb_wr_fsm (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire alsb_pkg::win_t   win,
    input  wire alsb_pkg::wr_in_t wr_in,
    output alsb_pkg::wr_out_t     wr_out
);
    import alsb_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic        awready_reg, awready_next;
    logic        wready_reg, wready_next;
    logic        bvalid_reg, bvalid_next;
    logic        req_reg, req_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] data_reg, data_next;
    logic [3:0]  strobe_reg, strobe_next;

    always_comb begin
        phase_next   = phase_reg;
        awready_next = awready_reg;
        wready_next  = wready_reg;
        bvalid_next  = bvalid_reg;
        req_next     = req_reg;
        offset_next  = offset_reg;
        data_next    = data_reg;
        strobe_next  = strobe_reg;
        case (phase_reg)
            PH_IDLE: begin
                awready_next = 1'b0;
                wready_next  = 1'b0;
                bvalid_next  = 1'b0;
                phase_next   = PH_ADDR;
            end
            PH_ADDR: begin
                if (wr_in.addr_valid && wr_in.data_valid && in_window(wr_in.addr, win)) begin
                    offset_next  = wr_in.addr - win.base;
                    data_next    = wr_in.data;
                    strobe_next  = wr_in.strobe;
                    req_next     = 1'b1;
                    awready_next = 1'b1;
                    phase_next   = PH_WAIT;
                end else begin
                    // no address, address without data, or outside the window
                    phase_next = PH_IDLE;
                end
            end
            PH_WAIT: begin
                if (wr_in.local_ready) begin
                    wready_next = 1'b1;
                    if (wr_in.resp_ready) begin
                        bvalid_next = 1'b1;
                        req_next    = 1'b0;
                        phase_next  = PH_IDLE;
                    end else begin
                        phase_next = PH_LAST;
                    end
                end
            end
            default: begin
                if (wr_in.resp_ready) begin
                    bvalid_next = 1'b1;
                    req_next    = 1'b0;
                    phase_next  = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            awready_reg <= 1'b0;
            wready_reg  <= 1'b0;
            bvalid_reg  <= 1'b0;
            req_reg     <= 1'b0;
            offset_reg  <= '0;
            data_reg    <= '0;
            strobe_reg  <= '0;
        end else if (en) begin
            phase_reg   <= phase_next;
            awready_reg <= awready_next;
            wready_reg  <= wready_next;
            bvalid_reg  <= bvalid_next;
            req_reg     <= req_next;
            offset_reg  <= offset_next;
            data_reg    <= data_next;
            strobe_reg  <= strobe_next;
        end
    end

    assign wr_out.addr_ready = awready_reg;
    assign wr_out.data_ready = wready_reg;
    assign wr_out.resp_valid = bvalid_reg;
    assign wr_out.offset     = offset_reg;
    assign wr_out.data       = data_reg;
    assign wr_out.strobe     = strobe_reg;
    assign wr_out.request    = req_reg;

endmodule

`default_nettype wire

FILE: rtl/core/axi_lite_slave_bridge_top.sv
// slave bridge top: an input stage, then the machine state registers holding the result
// throughput one item per cycle without output stall; the limit is the state feedback
// through each machine's next-state logic (window compare and offset subtract)
// reset (aresetn low, synchronous): both machines idle, all flags and latched
// values zero, window_base 0, window_top 4096, both stream stages empty
// depends on alsb_pkg, alsb_rd_fsm, alsb_wr_fsm
`default_nettype none

module axi_lite_slave_bridge_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input items
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // from bit 0: read_addr_valid, read_addr[32], local_read_ready, write_addr_valid,
    // write_addr[32], write_data_valid, write_data[32], write_strobe[4],
    // local_write_ready, resp_ready, zero pad
    input  wire logic [alsb_pkg::IN_W-1:0]  s_axis_tdata,
    // result items
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // from bit 0: read_addr_ready, read_valid, local_read_offset[32], local_read_request,
    // write_addr_ready, write_ready, resp_valid, local_write_offset[32],
    // local_write_data[32], local_write_strobe[4], local_write_request, zero pad
    output logic [alsb_pkg::OUT_W-1:0]      m_axis_tdata,
    // configuration writes
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [31:0]                cfg_data
);
    import alsb_pkg::*;

    localparam int OUT_PAD = OUT_W - OUT_BITS;

    // window registers
    logic [31:0] base_reg;
    logic [31:0] top_reg;
    win_t        win;

    // input stage
    logic            in_valid_reg, in_valid_next;
    logic [IN_W-1:0] in_data_reg;

    // result stage: payload lives in the machine state registers
    logic out_valid_reg, out_valid_next;
    logic advance;

    rd_in_t  rd_in;
    wr_in_t  wr_in;
    rd_out_t rd_out;
    wr_out_t wr_out;

    // config port always ready, unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            top_reg  <= 32'd4096;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WINDOW_BASE: base_reg <= cfg_data;
                REG_WINDOW_TOP:  top_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign win.base = base_reg;
    assign win.top  = top_reg;

    // step the machines when an item is held and the result slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata;
        end
    end

    // unpack the held item
    assign rd_in.addr_valid  = in_data_reg[0];
    assign rd_in.addr        = in_data_reg[32:1];
    assign rd_in.local_ready = in_data_reg[33];
    assign wr_in.addr_valid  = in_data_reg[34];
    assign wr_in.addr        = in_data_reg[66:35];
    assign wr_in.data_valid  = in_data_reg[67];
    assign wr_in.data        = in_data_reg[99:68];
    assign wr_in.strobe      = in_data_reg[103:100];
    assign wr_in.local_ready = in_data_reg[104];
    assign wr_in.resp_ready  = in_data_reg[105];

    alsb_rd_fsm u_rd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .win     (win),
        .rd_in   (rd_in),
        .rd_out  (rd_out)
    );

    alsb_wr_fsm u_wr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .win     (win),
        .wr_in   (wr_in),
        .wr_out  (wr_out)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {OUT_PAD{1'b0}},
        wr_out.request,
        wr_out.strobe,
        wr_out.data,
        wr_out.offset,
        wr_out.resp_valid,
        wr_out.data_ready,
        wr_out.addr_ready,
        rd_out.request,
        rd_out.offset,
        rd_out.data_valid,
        rd_out.addr_ready
    };

    // read data valid is only raised as the local request drops
    a_rd_req_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_out.data_valid && rd_out.request))
        else $error("read valid and local read request both high");

    // write response is only raised as the local request drops
    a_wr_req_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_out.resp_valid && wr_out.request))
        else $error("write response and local write request both high");

    // write data ready never comes ahead of write address ready
    a_wready_order: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_out.data_ready |-> wr_out.addr_ready)
        else $error("write ready without write address ready");

    // machine state only moves when an item is stepped
    a_hold_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(rd_out) && $stable(wr_out)))
        else $error("handshake state changed without an item");

endmodule

`default_nettype wire
